// File: rtl/core/pvu_pkg.sv
// shared types, constants and rounding helpers for the perpendicular unit vector block
// no dependencies
`default_nettype none

package pvu_pkg;

   localparam int NORM_W = 30;
   localparam int LEN_W = 31;
   localparam int COMP_W = 32;
   localparam int TOL_W = 11;
   localparam logic [TOL_W-1:0] TOL_RESET = 11'd11;
   localparam logic signed [COMP_W-1:0] ONE_Q30 = 32'sh4000_0000;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_ZERO_LINE   = 2'd1,
      STATUS_ZERO_VECTOR = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] x;
      logic signed [COMP_W-1:0] y;
      logic signed [COMP_W-1:0] z;
      status_type               status;
   } result_type;

   // round half away from zero, 30 bits
   function automatic logic signed [34:0] round_q30(input logic signed [63:0] x);
      logic [63:0] m;
      logic [63:0] r;
      m = x[63] ? 64'(-x) : 64'(x);
      r = (m + 64'(1) * (64'd1 << 29)) >> 30;
      round_q30 = x[63] ? -$signed(r[34:0]) : $signed(r[34:0]);
   endfunction

   // round half away from zero, 22 bits
   function automatic logic signed [44:0] round_q22(input logic signed [66:0] x);
      logic [66:0] m;
      logic [66:0] r;
      m = x[66] ? 67'(-x) : 67'(x);
      r = (m + (67'd1 << 21)) >> 22;
      round_q22 = x[66] ? -$signed(r[44:0]) : $signed(r[44:0]);
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/pvu_unitize.sv
// pipelined 3-d vector normalizer: shift to range, square sum, bit-serial sqrt, three dividers
// depends on pvu_pkg
`default_nettype none

module pvu_unitize import pvu_pkg::*; #(
   parameter int IW = 33,
   parameter int SW = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [2:0][IW-1:0]           in_vec,
   input  logic [SW-1:0]                in_side,
   output logic                         out_valid,
   output logic [2:0][COMP_W-1:0]       out_vec,
   output logic                         out_zero,
   output logic [SW-1:0]                out_side
);

   localparam int PW = $clog2(IW);
   localparam int CW = SW + 3;
   localparam int SUM_W = 2 * LEN_W;
   localparam int NUM_W = 2 * NORM_W + 1;

   // front stages
   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [2:0][IW-1:0] a1_ff, a2_ff, a3_ff;
   logic [CW-1:0]     c1_ff, c2_ff, c3_ff, c4_ff, c5_ff;
   logic [IW-1:0]     m2_ff;
   logic [PW-1:0]     p3_ff;
   logic              z3_ff, z4_ff, z5_ff;
   logic [2:0][NORM_W-1:0] b4_ff, b5_ff;
   logic [2:0][2*NORM_W-1:0] sq5_ff;

   logic [2:0][IW-1:0] a1_in;
   logic [2:0]        neg_in;
   logic [IW-1:0]     m2_in;
   logic [PW-1:0]     p3_in;
   logic [2:0][NORM_W-1:0] b4_in;
   logic [IW+NORM_W-2:0] ext;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = in_vec[i][IW-1];
         a1_in[i] = neg_in[i] ? IW'(-in_vec[i]) : in_vec[i];
      end
      m2_in = a1_ff[0];
      if (a1_ff[1] > m2_in) m2_in = a1_ff[1];
      if (a1_ff[2] > m2_in) m2_in = a1_ff[2];
      p3_in = '0;
      for (int b = 0; b < IW; b++) begin
         if (m2_ff[b]) p3_in = PW'(b);
      end
      ext = '0;
      for (int i = 0; i < 3; i++) begin
         ext = {a3_ff[i], {(NORM_W-1){1'b0}}} >> p3_ff;
         b4_in[i] = ext[NORM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff <= a1_in;
         c1_ff <= {in_side, neg_in};
         a2_ff <= a1_ff;
         m2_ff <= m2_in;
         c2_ff <= c1_ff;
         a3_ff <= a2_ff;
         p3_ff <= p3_in;
         z3_ff <= (m2_ff == '0);
         c3_ff <= c2_ff;
         b4_ff <= b4_in;
         z4_ff <= z3_ff;
         c4_ff <= c3_ff;
         for (int i = 0; i < 3; i++) begin
            sq5_ff[i] <= b4_ff[i] * b4_ff[i];
         end
         b5_ff <= b4_ff;
         z5_ff <= z4_ff;
         c5_ff <= c4_ff;
      end
   end

   // square root, two radicand bits a stage
   logic                   sv_ff [0:LEN_W];
   logic [SUM_W-1:0]       ss_ff [0:LEN_W];
   logic [LEN_W+2:0]       srem_ff [0:LEN_W];
   logic [LEN_W-1:0]       sroot_ff [0:LEN_W];
   logic [2:0][NORM_W-1:0] sb_ff [0:LEN_W];
   logic                   sz_ff [0:LEN_W];
   logic [CW-1:0]          sc_ff [0:LEN_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ss_ff[0] <= SUM_W'(sq5_ff[0]) + SUM_W'(sq5_ff[1]) + SUM_W'(sq5_ff[2]);
         srem_ff[0] <= '0;
         sroot_ff[0] <= '0;
         sb_ff[0] <= b5_ff;
         sz_ff[0] <= z5_ff;
         sc_ff[0] <= c5_ff;
      end
   end

   for (genvar k = 0; k < LEN_W; k++) begin : g_sqrt
      localparam int J = LEN_W - 1 - k;
      logic [LEN_W+2:0] rn;
      logic [LEN_W+2:0] trial;
      logic             take;

      always_comb begin
         rn = {srem_ff[k][LEN_W:0], ss_ff[k][2*J+1 -: 2]};
         trial = {1'b0, sroot_ff[k], 2'b01};
         take = (rn >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else if (en) begin
            sv_ff[k+1] <= sv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ss_ff[k+1] <= ss_ff[k];
            srem_ff[k+1] <= take ? rn - trial : rn;
            sroot_ff[k+1] <= {sroot_ff[k][LEN_W-2:0], take};
            sb_ff[k+1] <= sb_ff[k];
            sz_ff[k+1] <= sz_ff[k];
            sc_ff[k+1] <= sc_ff[k];
         end
      end
   end

   // three restoring dividers, one quotient bit a stage
   logic                    dv_ff [0:LEN_W];
   logic [LEN_W-1:0]        dlen_ff [0:LEN_W];
   logic [2:0][LEN_W:0]     drem_ff [0:LEN_W];
   logic [2:0][LEN_W-1:0]   dlo_ff [0:LEN_W];
   logic [2:0][LEN_W-1:0]   dq_ff [0:LEN_W];
   logic                    dz_ff [0:LEN_W];
   logic [CW-1:0]           dc_ff [0:LEN_W];
   logic [2:0][NUM_W-1:0]   num_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = {1'b0, sb_ff[LEN_W][i], {NORM_W{1'b0}}}
                     + NUM_W'(sroot_ff[LEN_W] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= sv_ff[LEN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dlen_ff[0] <= sroot_ff[LEN_W];
         for (int i = 0; i < 3; i++) begin
            drem_ff[0][i] <= (LEN_W+1)'(num_in[i][NUM_W-1:LEN_W]);
            dlo_ff[0][i] <= num_in[i][LEN_W-1:0];
            dq_ff[0][i] <= '0;
         end
         dz_ff[0] <= sz_ff[LEN_W];
         dc_ff[0] <= sc_ff[LEN_W];
      end
   end

   for (genvar k = 0; k < LEN_W; k++) begin : g_div
      localparam int J = LEN_W - 1 - k;
      logic [2:0][LEN_W:0] rn;
      logic [2:0]          take;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            rn[i] = {drem_ff[k][i][LEN_W-1:0], dlo_ff[k][i][J]};
            take[i] = (rn[i] >= {1'b0, dlen_ff[k]});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (en) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dlen_ff[k+1] <= dlen_ff[k];
            for (int i = 0; i < 3; i++) begin
               drem_ff[k+1][i] <= take[i] ? rn[i] - {1'b0, dlen_ff[k]} : rn[i];
               dq_ff[k+1][i] <= {dq_ff[k][i][LEN_W-2:0], take[i]};
            end
            dlo_ff[k+1] <= dlo_ff[k];
            dz_ff[k+1] <= dz_ff[k];
            dc_ff[k+1] <= dc_ff[k];
         end
      end
   end

   // sign restore
   logic                  ov_ff;
   logic [2:0][COMP_W-1:0] ovec_ff;
   logic                  oz_ff;
   logic [SW-1:0]         oside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= dv_ff[LEN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            ovec_ff[i] <= dc_ff[LEN_W][i] ? -COMP_W'(dq_ff[LEN_W][i])
                                          : COMP_W'(dq_ff[LEN_W][i]);
         end
         oz_ff <= dz_ff[LEN_W];
         oside_ff <= dc_ff[LEN_W][CW-1:3];
      end
   end

   assign out_valid = ov_ff;
   assign out_vec = ovec_ff;
   assign out_zero = oz_ff;
   assign out_side = oside_ff;

endmodule

`default_nettype wire

// File: rtl/core/perpendicular_unit_vector.sv
// top level: unit vector perpendicular to a 3-d line, one gram-schmidt step
// depends on pvu_pkg and pvu_unitize
//
//   channel | ports         | direction | contents
//   req     | req_*         | in        | two line points, seed flag, seed vector
//   rsp     | rsp_*         | out       | unit normal and status
//   csr     | csr_*         | in        | parallel tolerance write
//
// one item per cycle while req_ready is high; the path from acceptance to rsp_valid runs
// mostly through the two normalizers (31 stage square root then 31 stage divider each)
// synchronous reset clears valid bits and sets the tolerance to 11
// a global stall freezes the pipeline only when both output slots are full,
// so items keep flowing while one result waits
`default_nettype none

module perpendicular_unit_vector import pvu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [31:0]       req_line_start_x,
   input  logic signed [31:0]       req_line_start_y,
   input  logic signed [31:0]       req_line_start_z,
   input  logic signed [31:0]       req_line_end_x,
   input  logic signed [31:0]       req_line_end_y,
   input  logic signed [31:0]       req_line_end_z,
   input  logic                     req_has_seed,
   input  logic signed [31:0]       req_seed_x,
   input  logic signed [31:0]       req_seed_y,
   input  logic signed [31:0]       req_seed_z,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [31:0]       rsp_normal_x,
   output logic signed [31:0]       rsp_normal_y,
   output logic signed [31:0]       rsp_normal_z,
   output logic [1:0]               rsp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [TOL_W-1:0]         csr_data
);

   localparam int D_W = 33;
   localparam int W_W = 46;
   localparam int SIDE_W = 1 + 3 * COMP_W;

   logic adv;
   logic [TOL_W-1:0] tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   // difference stage
   logic              d_v_ff;
   logic [2:0][D_W-1:0] d_ff;
   logic [SIDE_W-1:0] d_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (adv) begin
         d_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff[0] <= D_W'(req_line_end_x) - D_W'(req_line_start_x);
         d_ff[1] <= D_W'(req_line_end_y) - D_W'(req_line_start_y);
         d_ff[2] <= D_W'(req_line_end_z) - D_W'(req_line_start_z);
         d_side_ff <= {req_has_seed, req_seed_z, req_seed_y, req_seed_x};
      end
   end

   logic                   u1_v;
   logic [2:0][COMP_W-1:0] u1_n;
   logic                   u1_z;
   logic [SIDE_W-1:0]      u1_side;

   pvu_unitize #(.IW(D_W), .SW(SIDE_W)) u_dir (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (d_v_ff),
      .in_vec    (d_ff),
      .in_side   (d_side_ff),
      .out_valid (u1_v),
      .out_vec   (u1_n),
      .out_zero  (u1_z),
      .out_side  (u1_side)
   );

   // start vector, dot products, rejection
   logic [8:1] mv_ff;
   logic [8:1] mz_ff;
   logic signed [COMP_W-1:0] n_ff [1:6][3];
   logic signed [COMP_W-1:0] v_ff [1:7][3];
   logic signed [COMP_W-1:0] vr_ff [2:4][3];
   logic signed [63:0] p2_ff [3];
   logic signed [63:0] q2_ff [3];
   logic signed [63:0] acc3_ff, accr3_ff;
   logic signed [34:0] dot4_ff, dotr4_ff, dot5_ff;
   logic signed [66:0] e6_ff [3];
   logic signed [44:0] r7_ff [3];
   logic [2:0][W_W-1:0] w8_ff;

   logic [COMP_W-1:0] nmag [3];
   logic [1:0] best;
   logic signed [COMP_W-1:0] v1_in [3];
   logic [34:0] dmag;
   logic signed [35:0] dev_t;
   logic [35:0] dev;
   logic par;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nmag[i] = u1_n[i][COMP_W-1] ? COMP_W'(-$signed(u1_n[i])) : u1_n[i];
      end
      best = 2'd0;
      if (nmag[1] < nmag[0]) best = 2'd1;
      if (nmag[2] < nmag[best]) best = 2'd2;
      for (int i = 0; i < 3; i++) begin
         if (u1_side[SIDE_W-1]) begin
            v1_in[i] = $signed(u1_side[i*COMP_W +: COMP_W]);
         end else begin
            v1_in[i] = (best == 2'(i)) ? ONE_Q30 : '0;
         end
      end
      dmag = dot4_ff[34] ? 35'(-dot4_ff) : 35'(dot4_ff);
      dev_t = $signed({1'b0, dmag}) - 36'sd1073741824;
      dev = dev_t[35] ? 36'(-dev_t) : 36'(dev_t);
      par = (dev < 36'(tol_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= '0;
      end else if (adv) begin
         mv_ff <= {mv_ff[7:1], u1_v};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mz_ff <= {mz_ff[7:1], u1_z};
         for (int i = 0; i < 3; i++) begin
            n_ff[1][i] <= $signed(u1_n[i]);
            v_ff[1][i] <= v1_in[i];
            p2_ff[i] <= n_ff[1][i] * v_ff[1][i];
            q2_ff[i] <= n_ff[1][i] * v_ff[1][(i+1)%3];
            vr_ff[2][i] <= v_ff[1][(i+1)%3];
            for (int s = 2; s <= 6; s++) begin
               n_ff[s][i] <= n_ff[s-1][i];
            end
            for (int s = 2; s <= 4; s++) begin
               v_ff[s][i] <= v_ff[s-1][i];
            end
            vr_ff[3][i] <= vr_ff[2][i];
            vr_ff[4][i] <= vr_ff[3][i];
            v_ff[5][i] <= par ? vr_ff[4][i] : v_ff[4][i];
            v_ff[6][i] <= v_ff[5][i];
            v_ff[7][i] <= v_ff[6][i];
            e6_ff[i] <= 67'(dot5_ff) * 67'(n_ff[5][i]);
            r7_ff[i] <= round_q22(e6_ff[i]);
            w8_ff[i] <= (W_W'(v_ff[7][i]) <<< 8) - W_W'(r7_ff[i]);
         end
         acc3_ff <= p2_ff[0] + p2_ff[1] + p2_ff[2];
         accr3_ff <= q2_ff[0] + q2_ff[1] + q2_ff[2];
         dot4_ff <= round_q30(acc3_ff);
         dotr4_ff <= round_q30(accr3_ff);
         dot5_ff <= par ? dotr4_ff : dot4_ff;
      end
   end

   logic                   u2_v;
   logic [2:0][COMP_W-1:0] u2_r;
   logic                   u2_z;
   logic                   u2_line0;

   pvu_unitize #(.IW(W_W), .SW(1)) u_rej (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (mv_ff[8]),
      .in_vec    (w8_ff),
      .in_side   (mz_ff[8]),
      .out_valid (u2_v),
      .out_vec   (u2_r),
      .out_zero  (u2_z),
      .out_side  (u2_line0)
   );

   // result and two-slot output buffer
   result_type res;

   always_comb begin
      res.x = '0;
      res.y = '0;
      res.z = '0;
      if (u2_line0) begin
         res.status = STATUS_ZERO_LINE;
      end else if (u2_z) begin
         res.status = STATUS_ZERO_VECTOR;
      end else begin
         res.status = STATUS_OK;
         res.x = $signed(u2_r[0]);
         res.y = $signed(u2_r[1]);
         res.z = $signed(u2_r[2]);
      end
   end

   logic out_v_ff, skid_v_ff;
   result_type out_ff, skid_ff;
   logic pop, push;

   assign adv = !skid_v_ff;
   assign req_ready = adv;
   assign pop = out_v_ff && rsp_ready;
   assign push = adv && u2_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) skid_v_ff <= 1'b0;
      end else if (push) begin
         if (out_v_ff && !pop) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_v_ff <= 1'b1;
         end
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) out_ff <= skid_ff;
      end else if (push) begin
         if (out_v_ff && !pop) begin
            skid_ff <= res;
         end else begin
            out_ff <= res;
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_normal_x = out_ff.x;
   assign rsp_normal_y = out_ff.y;
   assign rsp_normal_z = out_ff.z;
   assign rsp_status = out_ff.status;

endmodule

`default_nettype wire

// File: rtl/core/pvu_checker.sv
// port-level checks for perpendicular_unit_vector, bound to the top level
// depends on pvu_pkg
`default_nettype none

module pvu_checker import pvu_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [31:0] rsp_normal_x,
   input logic signed [31:0] rsp_normal_y,
   input logic signed [31:0] rsp_normal_z,
   input logic [1:0]        rsp_status
);

   // no item comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // failed items carry a zero vector
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_normal_z == 0)
      else $error("failed item with nonzero vector");

   // good items are never the zero vector
   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |->
         rsp_normal_x != 0 || rsp_normal_y != 0 || rsp_normal_z != 0)
      else $error("ok item with zero vector");

   // a stalled result stays valid and holds its x component and status
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_normal_x)
         && $stable(rsp_status))
      else $error("stalled result changed");

   // input is held off only while a result waits
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

endmodule

bind perpendicular_unit_vector pvu_checker u_pvu_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_normal_x (rsp_normal_x),
   .rsp_normal_y (rsp_normal_y),
   .rsp_normal_z (rsp_normal_z),
   .rsp_status   (rsp_status)
);

`default_nettype wire
